/* design/krc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// Shared types, codes and character tables for the key repeat character queue.
package krc_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int NUM_KEYS_DEF = 49;

  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW = 1;

  localparam logic [1:0] OP_KEY = 2'd0;
  localparam logic [1:0] OP_READ = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] REG_REPEAT_DELAY = 2'd0;
  localparam logic [1:0] REG_REPEAT_INTERVAL = 2'd1;

  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_PUSH = 2'd1;
  localparam logic [1:0] CMD_POP = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
  } cmd_t;

  function automatic logic [7:0] plain_char(input logic [5:0] k);
    logic [7:0] c;
    case (k)
      6'd0: c = 8'h31;  6'd1: c = 8'h32;  6'd2: c = 8'h33;  6'd3: c = 8'h34;
      6'd4: c = 8'h35;  6'd5: c = 8'h36;  6'd6: c = 8'h37;  6'd7: c = 8'h38;
      6'd8: c = 8'h39;  6'd9: c = 8'h30;  6'd10: c = 8'h2D; 6'd11: c = 8'h5E;
      6'd12: c = 8'h5C; 6'd13: c = 8'h51; 6'd14: c = 8'h57; 6'd15: c = 8'h45;
      6'd16: c = 8'h52; 6'd17: c = 8'h54; 6'd18: c = 8'h59; 6'd19: c = 8'h55;
      6'd20: c = 8'h49; 6'd21: c = 8'h4F; 6'd22: c = 8'h50; 6'd23: c = 8'h40;
      6'd24: c = 8'h5B; 6'd25: c = 8'h41; 6'd26: c = 8'h53; 6'd27: c = 8'h44;
      6'd28: c = 8'h46; 6'd29: c = 8'h47; 6'd30: c = 8'h48; 6'd31: c = 8'h4A;
      6'd32: c = 8'h4B; 6'd33: c = 8'h4C; 6'd34: c = 8'h3B; 6'd35: c = 8'h3A;
      6'd36: c = 8'h5D; 6'd37: c = 8'h5A; 6'd38: c = 8'h58; 6'd39: c = 8'h43;
      6'd40: c = 8'h56; 6'd41: c = 8'h42; 6'd42: c = 8'h4E; 6'd43: c = 8'h4D;
      6'd44: c = 8'h2C; 6'd45: c = 8'h2E; 6'd46: c = 8'h2F; 6'd47: c = 8'h7F;
      6'd48: c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] shift_char(input logic [5:0] k);
    logic [7:0] c;
    case (k)
      6'd0: c = 8'h21;  6'd1: c = 8'h22;  6'd2: c = 8'h23;  6'd3: c = 8'h24;
      6'd4: c = 8'h25;  6'd5: c = 8'h26;  6'd6: c = 8'h27;  6'd7: c = 8'h28;
      6'd8: c = 8'h29;  6'd9: c = 8'h00;  6'd10: c = 8'h3D; 6'd11: c = 8'h7E;
      6'd12: c = 8'h7C; 6'd13: c = 8'h71; 6'd14: c = 8'h77; 6'd15: c = 8'h65;
      6'd16: c = 8'h72; 6'd17: c = 8'h74; 6'd18: c = 8'h79; 6'd19: c = 8'h75;
      6'd20: c = 8'h69; 6'd21: c = 8'h6F; 6'd22: c = 8'h70; 6'd23: c = 8'h60;
      6'd24: c = 8'h7B; 6'd25: c = 8'h61; 6'd26: c = 8'h73; 6'd27: c = 8'h64;
      6'd28: c = 8'h66; 6'd29: c = 8'h67; 6'd30: c = 8'h68; 6'd31: c = 8'h6A;
      6'd32: c = 8'h6B; 6'd33: c = 8'h6C; 6'd34: c = 8'h2B; 6'd35: c = 8'h2A;
      6'd36: c = 8'h7D; 6'd37: c = 8'h7A; 6'd38: c = 8'h78; 6'd39: c = 8'h63;
      6'd40: c = 8'h76; 6'd41: c = 8'h62; 6'd42: c = 8'h6E; 6'd43: c = 8'h6D;
      6'd44: c = 8'h3C; 6'd45: c = 8'h3E; 6'd46: c = 8'h3F; 6'd47: c = 8'h5F;
      6'd48: c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

/* design/krc_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// Front end: accepts requests, runs the per-key repeat timers and issues queue commands.
module krc_front #(
  parameter int NUM_KEYS = krc_pkg::NUM_KEYS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  output logic              busy,
  input  wire logic [1:0]   operation,
  input  wire logic [5:0]   key_index,
  input  wire logic         key_pressed,
  input  wire logic         left_shift,
  input  wire logic         right_shift,
  input  wire logic         cfg_valid,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [6:0]   cfg_data,
  input  wire logic         q_full,
  output logic              q_push,
  output krc_pkg::cmd_t     q_cmd
);
  import krc_pkg::*;

  localparam int KEY_AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                state;
  logic [6:0]          repeat_delay;
  logic [6:0]          repeat_interval;
  logic [7:0]          timer_mem [NUM_KEYS];
  logic [NUM_KEYS-1:0] timer_vld;
  logic [7:0]          timer_rd;
  logic                vld_rd;
  logic [1:0]          op;
  logic [5:0]          key;
  logic                pressed;
  logic                shift;
  logic                in_range;

  logic                accept;
  logic                in_range_now;
  logic [KEY_AW-1:0]   rd_addr;
  logic [KEY_AW-1:0]   wr_addr;
  logic [7:0]          t_cur;
  logic [8:0]          t_inc;
  logic [8:0]          limit;
  logic [7:0]          t_new;
  logic                emit;
  logic [7:0]          ch;
  logic                key_op;

  assign busy = (state == ST_EXEC) || q_full;
  assign accept = start && !busy;
  assign in_range_now = {1'b0, key_index} < 7'(NUM_KEYS);
  assign rd_addr = in_range_now ? key_index[KEY_AW-1:0] : '0;
  assign wr_addr = key[KEY_AW-1:0];

  assign key_op = (op == OP_KEY) && in_range;
  assign t_cur = vld_rd ? timer_rd : 8'd0;
  assign emit = (t_cur == 8'd0) || (t_cur == {1'b0, repeat_delay});
  assign ch = shift ? shift_char(key) : plain_char(key);
  assign t_inc = {1'b0, t_cur} + 9'd1;
  assign limit = {2'b00, repeat_delay} + {2'b00, repeat_interval};
  assign t_new = (t_inc >= limit) ? {1'b0, repeat_delay} : t_inc[7:0];

  always_comb begin
    q_push = (state == ST_EXEC);
    q_cmd.ch = ch;
    case (op)
      OP_KEY: q_cmd.kind = (key_op && pressed && emit && (ch != 8'd0)) ? CMD_PUSH : CMD_NONE;
      OP_READ: q_cmd.kind = CMD_POP;
      OP_CLEAR: q_cmd.kind = CMD_CLEAR;
      default: q_cmd.kind = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      repeat_delay <= 7'd20;
      repeat_interval <= 7'd4;
      timer_vld <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_REPEAT_DELAY: repeat_delay <= cfg_data;
          REG_REPEAT_INTERVAL: repeat_interval <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EXEC;
          end
        end
        default: begin
          state <= ST_IDLE;
          if (key_op) begin
            timer_vld[wr_addr] <= 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op <= operation;
      key <= key_index;
      pressed <= key_pressed;
      shift <= left_shift ^ right_shift;
      in_range <= in_range_now;
      timer_rd <= timer_mem[rd_addr];
      vld_rd <= timer_vld[rd_addr];
    end
    if ((state == ST_EXEC) && key_op) begin
      timer_mem[wr_addr] <= pressed ? t_new : 8'd0;
    end
  end

endmodule
`default_nettype wire

/* design/krc_cmd_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// Short command queue between the front end and the character ring buffer.
module krc_cmd_fifo (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire krc_pkg::cmd_t push_cmd,
  input  wire logic         pop,
  output logic              full,
  output logic              not_empty,
  output krc_pkg::cmd_t     head_cmd
);
  import krc_pkg::*;

  cmd_t               entries [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr;
  logic [CMDQ_AW-1:0] rd_ptr;
  logic [CMDQ_AW:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full = (count == (CMDQ_AW + 1)'(CMDQ_DEPTH));
  assign not_empty = (count != '0);
  assign head_cmd = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

/* design/krc_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// Back end: character ring buffer that overwrites its oldest entry and drives results.
module krc_back #(
  parameter int QUEUE_DEPTH = krc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cmd_valid,
  input  wire krc_pkg::cmd_t cmd,
  output logic              done,
  output logic [7:0]        read_char,
  output logic              read_valid,
  output logic              char_queued,
  output logic              oldest_dropped
);
  import krc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic [7:0]       char_mem [QUEUE_DEPTH];
  logic [7:0]       rd_data;
  logic [PTR_W-1:0] head_ptr;
  logic [PTR_W-1:0] tail_ptr;
  logic [PTR_W-1:0] head_adv;
  logic [PTR_W-1:0] tail_adv;
  logic             not_empty;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head_adv = advance(head_ptr);
  assign tail_adv = advance(tail_ptr);
  assign not_empty = (head_ptr != tail_ptr);
  assign read_char = read_valid ? rd_data : 8'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr <= '0;
      tail_ptr <= '0;
      done <= 1'b0;
      read_valid <= 1'b0;
      char_queued <= 1'b0;
      oldest_dropped <= 1'b0;
    end else begin
      done <= cmd_valid;
      read_valid <= 1'b0;
      char_queued <= 1'b0;
      oldest_dropped <= 1'b0;
      if (cmd_valid) begin
        case (cmd.kind)
          CMD_PUSH: begin
            char_queued <= 1'b1;
            tail_ptr <= tail_adv;
            if (tail_adv == head_ptr) begin
              head_ptr <= head_adv;
              oldest_dropped <= 1'b1;
            end
          end
          CMD_POP: begin
            if (not_empty) begin
              read_valid <= 1'b1;
              head_ptr <= head_adv;
            end
          end
          CMD_CLEAR: begin
            head_ptr <= '0;
            tail_ptr <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && (cmd.kind == CMD_PUSH)) begin
      char_mem[tail_ptr] <= cmd.ch;
    end
    rd_data <= char_mem[head_ptr];
  end

endmodule
`default_nettype wire

/* design/key_repeat_char_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// Top level of the typematic key repeat front end with an overwriting character queue.
// An accepted request is registered by the front end, goes through the command queue,
// and its result is strobed by the done register of the back end; every request gives
// exactly one result. Busy holds off new requests during a hold timer read-modify-write.
// Reset clears the timers, the queue pointers and both repeat registers to their defaults.
// The receiver cannot stall; results are taken in the cycle that done is high.
module key_repeat_char_fifo #(
  parameter int QUEUE_DEPTH = krc_pkg::QUEUE_DEPTH_DEF,
  parameter int NUM_KEYS = krc_pkg::NUM_KEYS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] operation,
  input  wire logic [5:0] key_index,
  input  wire logic       key_pressed,
  input  wire logic       left_shift,
  input  wire logic       right_shift,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [6:0] cfg_data,
  output logic            done,
  output logic [7:0]      read_char,
  output logic            read_valid,
  output logic            char_queued,
  output logic            oldest_dropped
);
  import krc_pkg::*;

  logic q_full;
  logic q_push;
  logic q_not_empty;
  cmd_t q_in;
  cmd_t q_out;

  assign cfg_ready = 1'b1;

  krc_front #(
    .NUM_KEYS(NUM_KEYS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operation(operation),
    .key_index(key_index),
    .key_pressed(key_pressed),
    .left_shift(left_shift),
    .right_shift(right_shift),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .q_full(q_full),
    .q_push(q_push),
    .q_cmd(q_in)
  );

  krc_cmd_fifo u_fifo (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .push_cmd(q_in),
    .pop(q_not_empty),
    .full(q_full),
    .not_empty(q_not_empty),
    .head_cmd(q_out)
  );

  krc_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cmd_valid(q_not_empty),
    .cmd(q_out),
    .done(done),
    .read_char(read_char),
    .read_valid(read_valid),
    .char_queued(char_queued),
    .oldest_dropped(oldest_dropped)
  );

  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    !(read_valid && char_queued))
    else $error("A result both popped and queued a character.");

  a_drop_needs_write: assert property (@(posedge clk) disable iff (rst)
    oldest_dropped |-> char_queued)
    else $error("A character was dropped without a write.");

  a_flags_need_done: assert property (@(posedge clk) disable iff (rst)
    (read_valid || char_queued) |-> done)
    else $error("Result flags were raised outside a result cycle.");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("The front end did not hold off the next request.");

endmodule
`default_nettype wire

/* sim/key_repeat_char_fifo_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the key repeat character queue with typematic timing.
module key_repeat_char_fifo_tb;
  import krc_pkg::*;

  localparam int NUM_KEYS = NUM_KEYS_DEF;
  localparam int QDEPTH = QUEUE_DEPTH_DEF;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [5:0] key;
    logic       pressed;
    logic       lshift;
    logic       rshift;
  } key_request_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       popped;
    logic       stored;
    logic       dropped;
  } key_outcome_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [1:0] operation = OP_KEY;
  logic [5:0] key_index = 6'd0;
  logic       key_pressed = 1'b0;
  logic       left_shift = 1'b0;
  logic       right_shift = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [1:0] cfg_index = REG_REPEAT_DELAY;
  logic [6:0] cfg_data = 7'd0;
  logic       busy;
  logic       cfg_ready;
  logic       done;
  logic [7:0] read_char;
  logic       read_valid;
  logic       char_queued;
  logic       oldest_dropped;

  key_request_t key_requests[$];
  key_outcome_t outcome_fifo[$];
  logic         request_taken = 1'b0;
  logic         allow_gaps = 1'b1;
  int           gap_left = 0;
  int           error_count = 0;
  int           phase_items = 0;

  logic [7:0] hold_count[NUM_KEYS];
  logic [7:0] ring[QDEPTH];
  logic [3:0] ring_head;
  logic [3:0] ring_tail;
  logic [6:0] delay_reg;
  logic [6:0] interval_reg;

  string plain_keys = "1234567890-^\\QWERTYUIOP@[ASDFGHJKL;:]ZXCVBNM,./";
  string shift_keys = "!\"#$%&'()0=~|qwertyuiop@{asdfghjkl+*}zxcvbnm<>?";

  key_repeat_char_fifo uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operation(operation),
    .key_index(key_index),
    .key_pressed(key_pressed),
    .left_shift(left_shift),
    .right_shift(right_shift),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .done(done),
    .read_char(read_char),
    .read_valid(read_valid),
    .char_queued(char_queued),
    .oldest_dropped(oldest_dropped)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic logic [7:0] key_char(input int k, input logic shifted);
    if (k == 47) return shifted ? 8'h5F : 8'h7F;
    if (k == 48) return 8'h20;
    if (!shifted) return plain_keys[k];
    if (k == 9) return 8'h00;
    if (k == 23) return 8'h60;
    return shift_keys[k];
  endfunction

  function automatic void clear_ring();
    for (int i = 0; i < QDEPTH; i++) ring[i] = 8'h00;
    ring_head = 4'd0;
    ring_tail = 4'd0;
  endfunction

  function automatic void reset_model();
    for (int i = 0; i < NUM_KEYS; i++) hold_count[i] = 8'h00;
    clear_ring();
    delay_reg = 7'd20;
    interval_reg = 7'd4;
  endfunction

  function automatic void apply_register(input logic [1:0] idx, input logic [6:0] val);
    if (idx == REG_REPEAT_DELAY) delay_reg = val;
    else if (idx == REG_REPEAT_INTERVAL) interval_reg = val;
  endfunction

  function automatic key_outcome_t keyboard_outcome(input key_request_t r);
    key_outcome_t res;
    int t;
    logic [7:0] c;
    res = '0;
    case (r.op)
      OP_KEY: begin
        if (int'(r.key) < NUM_KEYS) begin
          if (r.pressed) begin
            t = int'(hold_count[r.key]);
            if (t == 0 || t == int'(delay_reg)) begin
              c = key_char(int'(r.key), r.lshift ^ r.rshift);
              if (c != 8'h00) begin
                res.stored = 1'b1;
                ring[ring_tail] = c;
                ring_tail = ring_tail + 4'd1;
                if (ring_head == ring_tail) begin
                  ring[ring_head] = 8'h00;
                  ring_head = ring_head + 4'd1;
                  res.dropped = 1'b1;
                end
              end
            end
            t = t + 1;
            if (t >= int'(delay_reg) + int'(interval_reg)) t = int'(delay_reg);
            hold_count[r.key] = t[7:0];
          end else begin
            hold_count[r.key] = 8'h00;
          end
        end
      end
      OP_READ: begin
        if (ring_head != ring_tail) begin
          res.ch = ring[ring_head];
          res.popped = 1'b1;
          ring[ring_head] = 8'h00;
          ring_head = ring_head + 4'd1;
        end
      end
      OP_CLEAR: clear_ring();
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    error_count++;
  endtask

  always @(negedge clk) begin : drive_requests
    key_request_t req;
    if (!rst && (!start || request_taken)) begin
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (allow_gaps && $urandom_range(0, 9) == 0) begin
        start <= 1'b0;
        gap_left <= $urandom_range(0, 12);
      end else if (key_requests.size() > 0) begin
        req = key_requests.pop_front();
        operation <= req.op;
        key_index <= req.key;
        key_pressed <= req.pressed;
        left_shift <= req.lshift;
        right_shift <= req.rshift;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_results
    key_outcome_t want;
    key_request_t got;
    if (rst) begin
      request_taken <= 1'b0;
    end else begin
      request_taken <= start && !busy;
      if (done) begin
        if (outcome_fifo.size() == 0) begin
          report_mismatch("result strobe with no request outstanding");
        end else begin
          want = outcome_fifo.pop_front();
          if (read_char !== want.ch)
            report_mismatch($sformatf("read_char %h, expected %h", read_char, want.ch));
          if (read_valid !== want.popped)
            report_mismatch($sformatf("read_valid %b, expected %b", read_valid, want.popped));
          if (char_queued !== want.stored)
            report_mismatch($sformatf("char_queued %b, expected %b", char_queued, want.stored));
          if (oldest_dropped !== want.dropped)
            report_mismatch($sformatf("oldest_dropped %b, expected %b",
                                      oldest_dropped, want.dropped));
        end
      end
      if (cfg_valid && cfg_ready) apply_register(cfg_index, cfg_data);
      if (start && !busy) begin
        got = '{operation, key_index, key_pressed, left_shift, right_shift};
        outcome_fifo.push_back(keyboard_outcome(got));
      end
    end
  end

  task automatic add_request(input logic [1:0] op, input logic [5:0] key,
                             input logic pressed, input logic ls, input logic rs);
    key_requests.push_back('{op, key, pressed, ls, rs});
    phase_items++;
  endtask

  task automatic add_op(input logic [1:0] op);
    add_request(op, 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic add_key_hold(input int max_frames);
    logic [5:0] key;
    logic ls;
    logic rs;
    int frames;
    key = ($urandom_range(0, 19) == 0) ? 6'($urandom_range(49, 63))
                                       : 6'($urandom_range(0, 48));
    ls = 1'($urandom_range(0, 1));
    rs = 1'($urandom_range(0, 1));
    frames = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 6) : $urandom_range(1, max_frames);
    for (int i = 0; i < frames; i++) begin
      if ($urandom_range(0, 11) == 0) ls = ~ls;
      add_request(OP_KEY, key, 1'b1, ls, rs);
      case ($urandom_range(0, 5))
        0, 1: add_op(OP_READ);
        2: if ($urandom_range(0, 9) == 0) add_op(OP_CLEAR);
        3: add_request(OP_KEY, 6'($urandom_range(0, 48)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        default: ;
      endcase
    end
    add_request(OP_KEY, key, 1'b0, ls, rs);
  endtask

  task automatic add_random_phase(input int dly, input int ivl, input int budget);
    int max_frames;
    max_frames = dly + 2 * ivl + 2;
    if (max_frames > 140) max_frames = 140;
    if (max_frames < 4) max_frames = 4;
    phase_items = 0;
    while (phase_items < budget) begin
      case ($urandom_range(0, 9))
        0: add_op(2'($urandom_range(0, 3)));
        1: repeat ($urandom_range(1, 6)) add_op(OP_READ);
        default: add_key_hold(max_frames);
      endcase
    end
  endtask

  task automatic wait_until_idle();
    @(negedge clk);
    while (key_requests.size() != 0 || start || outcome_fifo.size() != 0 || busy)
      @(negedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [6:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [6:0] dly, input logic [6:0] ivl, input int budget);
    wait_until_idle();
    write_register(REG_REPEAT_DELAY, dly);
    write_register(REG_REPEAT_INTERVAL, ivl);
    add_random_phase(int'(dly), int'(ivl), budget);
  endtask

  initial begin
    reset_model();
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    add_request(OP_READ, 6'd0, 1'b0, 1'b0, 1'b0);
    add_request(OP_UNUSED, 6'd63, 1'b1, 1'b1, 1'b1);
    add_request(OP_KEY, 6'd0, 1'b1, 1'b0, 1'b0);
    add_request(OP_KEY, 6'd0, 1'b1, 1'b0, 1'b0);
    add_request(OP_KEY, 6'd0, 1'b0, 1'b0, 1'b0);
    add_request(OP_KEY, 6'd9, 1'b1, 1'b1, 1'b0);
    add_request(OP_KEY, 6'd9, 1'b0, 1'b1, 1'b0);
    add_request(OP_KEY, 6'd47, 1'b1, 1'b1, 1'b1);
    add_request(OP_KEY, 6'd47, 1'b0, 1'b1, 1'b1);
    add_request(OP_KEY, 6'd47, 1'b1, 1'b0, 1'b1);
    add_request(OP_KEY, 6'd48, 1'b1, 1'b1, 1'b0);
    add_request(OP_KEY, 6'd12, 1'b1, 1'b0, 1'b0);
    add_request(OP_KEY, 6'd23, 1'b1, 1'b0, 1'b1);
    add_request(OP_KEY, 6'd63, 1'b1, 1'b0, 1'b0);
    add_request(OP_KEY, 6'd49, 1'b1, 1'b1, 1'b0);
    add_request(OP_READ, 6'd0, 1'b0, 1'b0, 1'b0);
    add_request(OP_READ, 6'd63, 1'b1, 1'b1, 1'b1);
    add_request(OP_CLEAR, 6'd0, 1'b0, 1'b0, 1'b0);
    add_request(OP_READ, 6'd0, 1'b0, 1'b0, 1'b0);
    add_request(OP_KEY, 6'd36, 1'b1, 1'b0, 1'b0);
    add_request(OP_CLEAR, 6'd63, 1'b1, 1'b1, 1'b1);
    add_request(OP_READ, 6'd0, 1'b0, 1'b0, 1'b0);
    add_random_phase(20, 4, 100);

    run_phase(7'd1, 7'd1, 80);
    run_phase(7'd127, 7'd1, 130);
    run_phase(7'd1, 7'd127, 100);
    run_phase(7'd0, 7'd0, 40);
    allow_gaps = 1'b0;
    run_phase(7'($urandom_range(1, 40)), 7'($urandom_range(1, 20)), 80);

    wait_until_idle();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
